[hw/rtl/jsfe_pkg.sv]
// Package for the JSON string field extractor: types, codes and character constants.
`default_nettype none

package jsfe_pkg;

    // Default size of the key that the search window supports.
    localparam int MAX_KEY_BYTES_DEF = 16;

    // Key bytes held in the two 64-bit key registers.
    localparam int KEY_REG_BYTES = 16;

    // Result queue depth and the most results that one document byte causes.
    localparam int FIFO_DEPTH   = 8;
    localparam int RES_PER_ITEM = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_LO  = 2'd0;
    localparam logic [1:0] REG_KEY_HI  = 2'd1;
    localparam logic [1:0] REG_KEY_LEN = 2'd2;
    localparam logic [1:0] REG_SKIP    = 2'd3;

    // Characters used by the pattern and the unescaper.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Document phase.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SEARCH,
        PH_VALUE,
        PH_DONE
    } t_phase;

    // Result kind.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    // One result item.
    typedef struct packed {
        logic [7:0] value_byte;
        t_kind      kind;
        logic       run_last;
    } t_result;

endpackage : jsfe_pkg

`default_nettype wire

[hw/rtl/json_string_field_extract_top.sv]
// Top level of the JSON string field extractor: window search, unescaper and result queue.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tdata[7:0] doc_byte, s_tlast doc_end
//  m_*     | out       | m_tvalid/m_tready  | m_tdata[7:0] value_byte, m_tuser[1:0] kind,
//          |           |                    | m_tlast run_last
//  i_cfg_* | in        | i_cfg_we only      | i_cfg_index register, i_cfg_data value
//
// A document byte is registered when accepted and handled in the next cycle, where its
// zero to three results enter an eight-entry result queue; the first one is visible on
// the master side in the cycle after that.  A byte is taken in every cycle as long as the
// queue has room for the results of the byte in flight and the new one, so the rate is
// one byte per cycle while each byte yields at most one result; bytes that yield more
// are bounded by the one-result-per-cycle drain of the queue.  The synchronous reset
// clears the phase, counters, flags, key registers and the queue; no clearing pass runs.
// A stall on the master side fills the queue and then drops s_tready.
`default_nettype none

module json_string_field_extract_top
    import jsfe_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    // Document byte stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] doc_byte
    input  wire         s_tlast,   // doc_end

    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] value_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // run_last

    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);

    localparam int WIN    = MAX_KEY_BYTES + 4;
    localparam int CW     = $clog2(WIN + 1);
    localparam int KLW    = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int FW     = $clog2(FIFO_DEPTH);

    // Configuration registers.
    logic [63:0]   r_key_lo;
    logic [63:0]   r_key_hi;
    logic [4:0]    r_key_len;
    logic [15:0]   r_search_skip;

    // Input register.
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_end;

    // Document state.
    t_phase        r_phase, n_phase;
    logic [7:0]    r_win [WIN];
    logic [7:0]    n_win [WIN];
    logic [CW-1:0] r_win_cnt, n_win_cnt;
    logic [15:0]   r_skip_left, n_skip_left;
    logic          r_raw_bs, n_raw_bs;
    logic          r_esc, n_esc;

    // Result queue.
    t_result       r_fifo [FIFO_DEPTH];
    logic [FW-1:0] r_wr_ptr;
    logic [FW-1:0] r_rd_ptr;
    logic [FW:0]   r_count;

    // Window search signals.
    logic [8*KEY_REG_BYTES-1:0] w_key_regs;
    logic [7:0]     w_key [MAX_KEY_BYTES];
    logic [KLW-1:0] w_klen;
    logic [CW-1:0]  w_plen;
    logic [7:0]     w_shift [WIN];
    logic [CW-1:0]  w_cnt_inc;
    logic           w_match;

    // Results of the byte being handled.
    t_result        w_res [RES_PER_ITEM];
    logic [1:0]     w_res_n;

    logic           w_in_fire;
    logic           w_out_fire;
    logic [FW+1:0]  w_need;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo      <= '0;
            r_key_hi      <= '0;
            r_key_len     <= '0;
            r_search_skip <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LO:  r_key_lo      <= i_cfg_data;
                REG_KEY_HI:  r_key_hi      <= i_cfg_data;
                REG_KEY_LEN: r_key_len     <= i_cfg_data[4:0];
                REG_SKIP:    r_search_skip <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input acceptance: room for the results of the byte in flight and of the new one.
    assign w_need = {1'b0, r_count}
                  + (r_in_valid ? (FW+2)'(RES_PER_ITEM) : '0)
                  + (FW+2)'(RES_PER_ITEM);
    assign s_tready  = (w_need <= (FW+2)'(FIFO_DEPTH));
    assign w_in_fire = s_tvalid & s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte <= s_tdata;
            r_in_end  <= s_tlast;
        end
    end

    // Key bytes; those beyond the two key registers read as zero.
    assign w_key_regs = {r_key_hi, r_key_lo};

    always_comb begin
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            w_key[i] = (i < KEY_REG_BYTES) ? w_key_regs[8*(i%KEY_REG_BYTES) +: 8] : 8'h00;
        end
    end

    // Effective key and pattern lengths.
    assign w_klen = (int'(r_key_len) > MAX_KEY_BYTES) ? KLW'(MAX_KEY_BYTES)
                                                      : KLW'(r_key_len);
    assign w_plen = CW'(w_klen) + CW'(4);

    // Window after the current byte is shifted in, newest byte at position zero.
    always_comb begin
        w_shift[0] = r_in_byte;
        for (int j = 1; j < WIN; j++) begin
            w_shift[j] = r_win[j-1];
        end
        w_cnt_inc = (int'(r_win_cnt) < WIN) ? r_win_cnt + CW'(1) : r_win_cnt;
    end

    // Parallel compare of the shifted window against quote, key, quote, colon, quote.
    always_comb begin
        int         diff;
        logic [7:0] pat;
        logic       all_eq;
        all_eq = 1'b1;
        for (int j = 0; j < WIN; j++) begin
            diff = int'(w_klen) + 2 - j;
            if (j == 0) begin
                pat = CH_QUOTE;
            end else if (j == 1) begin
                pat = CH_COLON;
            end else if (j == 2) begin
                pat = CH_QUOTE;
            end else if (diff >= 0) begin
                pat = w_key[diff[KIDX_W-1:0]];
            end else begin
                pat = CH_QUOTE;
            end
            if ((j < int'(w_plen)) && (w_shift[j] != pat)) begin
                all_eq = 1'b0;
            end
        end
        w_match = all_eq && (w_cnt_inc >= w_plen);
    end

    // Byte handling: next state and the results of this byte.
    always_comb begin
        logic       do_search;
        logic [7:0] b;
        b           = r_in_byte;
        do_search   = 1'b0;
        n_phase     = r_phase;
        n_win       = r_win;
        n_win_cnt   = r_win_cnt;
        n_skip_left = r_skip_left;
        n_raw_bs    = r_raw_bs;
        n_esc       = r_esc;
        w_res_n     = 2'd0;
        for (int e = 0; e < RES_PER_ITEM; e++) begin
            w_res[e] = '{value_byte: 8'h00, kind: KIND_BYTE, run_last: 1'b0};
        end

        if (r_in_valid) begin
            case (r_phase)
                PH_SKIP: begin
                    if (r_skip_left < r_search_skip) begin
                        n_skip_left = r_skip_left + 16'd1;
                    end else begin
                        do_search = 1'b1;
                    end
                end
                PH_SEARCH: begin
                    do_search = 1'b1;
                end
                PH_VALUE: begin
                    if ((b == CH_QUOTE) && !r_raw_bs) begin
                        w_res[w_res_n] = '{value_byte: 8'h00, kind: KIND_DONE, run_last: 1'b0};
                        w_res_n        = w_res_n + 2'd1;
                        n_phase        = PH_DONE;
                        n_esc          = 1'b0;
                    end else if (r_esc) begin
                        n_esc = 1'b0;
                        w_res[w_res_n].kind = KIND_BYTE;
                        case (b)
                            CH_N:      w_res[w_res_n].value_byte = CH_LF;
                            CH_T:      w_res[w_res_n].value_byte = CH_TAB;
                            CH_R:      w_res[w_res_n].value_byte = CH_CR;
                            CH_QUOTE:  w_res[w_res_n].value_byte = CH_QUOTE;
                            CH_BSLASH: w_res[w_res_n].value_byte = CH_BSLASH;
                            default: begin
                                // Unknown escape: the backslash, then the byte itself.
                                w_res[w_res_n].value_byte = CH_BSLASH;
                                w_res_n = w_res_n + 2'd1;
                                w_res[w_res_n].value_byte = b;
                            end
                        endcase
                        w_res_n = w_res_n + 2'd1;
                    end else if (b == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        w_res[w_res_n] = '{value_byte: b, kind: KIND_BYTE, run_last: 1'b0};
                        w_res_n        = w_res_n + 2'd1;
                    end
                    n_raw_bs = (b == CH_BSLASH);
                end
                PH_DONE: ;
                default: ;
            endcase

            if (do_search) begin
                n_phase   = PH_SEARCH;
                n_win     = w_shift;
                n_win_cnt = w_cnt_inc;
                if (w_match) begin
                    n_phase  = PH_VALUE;
                    n_raw_bs = 1'b0;
                    n_esc    = 1'b0;
                end
            end

            // Document end: report a missing or open value, then rearm.
            if (r_in_end) begin
                if (n_phase != PH_DONE) begin
                    w_res[w_res_n] = '{value_byte: 8'h00, kind: KIND_FAIL, run_last: 1'b0};
                    w_res_n        = w_res_n + 2'd1;
                end
                n_phase     = PH_SKIP;
                n_win_cnt   = '0;
                n_skip_left = '0;
                n_raw_bs    = 1'b0;
                n_esc       = 1'b0;
            end

            if (w_res_n != 2'd0) begin
                w_res[w_res_n - 2'd1].run_last = 1'b1;
            end
        end
    end

    // Document state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_win_cnt   <= '0;
            r_skip_left <= '0;
            r_raw_bs    <= 1'b0;
            r_esc       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_win_cnt   <= n_win_cnt;
            r_skip_left <= n_skip_left;
            r_raw_bs    <= n_raw_bs;
            r_esc       <= n_esc;
        end
    end

    // Window bytes carry no reset; only the fill count qualifies them.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // Result queue: up to three writes per cycle, one read.
    assign w_out_fire = m_tvalid & m_tready;

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < RES_PER_ITEM; e++) begin
            if (e < int'(w_res_n)) begin
                r_fifo[r_wr_ptr + FW'(e)] <= w_res[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FW'(w_res_n);
            if (w_out_fire) begin
                r_rd_ptr <= r_rd_ptr + FW'(1);
            end
            r_count <= r_count + (FW+1)'(w_res_n) - (FW+1)'(w_out_fire);
        end
    end

    // Master side driven from the queue head.
    assign m_tvalid = (r_count != '0);
    assign m_tdata  = r_fifo[r_rd_ptr].value_byte;
    assign m_tuser  = r_fifo[r_rd_ptr].kind;
    assign m_tlast  = r_fifo[r_rd_ptr].run_last;

endmodule : json_string_field_extract_top

`default_nettype wire

[sim/json_string_field_extract_checker.sv]
// Checker for the JSON string field extractor: predicts the result stream and compares it.
`timescale 1ns / 100ps

module json_string_field_extract_checker
    import jsfe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    // Document stream, observed only.
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] doc_byte
    input  wire         s_tlast,   // doc_end

    // Result stream, observed only.
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,   // [7:0] value_byte
    input  wire  [1:0]  m_tuser,   // [1:0] kind
    input  wire         m_tlast,   // run_last

    // Configuration writes, observed only.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,

    // Results still awaited and mismatches seen so far.
    output int          o_pending,
    output int          o_fail_count
);

    localparam int WIN_DEPTH = MAX_KEY_BYTES_DEF + 4;

    // Shadow copy of the configuration registers.
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len;
    logic [15:0] skip_len;

    // Shadow copy of the per-document state.
    t_phase      doc_phase;
    logic [7:0]  recent [WIN_DEPTH];
    int          win_fill;
    logic [15:0] skipped;
    logic        prev_was_bs;
    logic        esc_open;

    // Results of one document byte, and all extracted results not yet seen.
    t_result     burst [RES_PER_ITEM];
    int          burst_n;
    t_result     extracted_q [$];
    t_result     oldest;

    function automatic logic [7:0] key_char(input int i);
        if (i < 8) return key_lo[8*i +: 8];
        if (i < KEY_REG_BYTES) return key_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    // Byte k of the pattern quote, key, quote, colon, quote.
    function automatic logic [7:0] pattern_char(input int k, input int klen);
        if (k == 0) return CH_QUOTE;
        if (k <= klen) return key_char(k - 1);
        if (k == klen + 1) return CH_QUOTE;
        if (k == klen + 2) return CH_COLON;
        return CH_QUOTE;
    endfunction

    // The newest bytes form the pattern, oldest pattern byte deepest in the window.
    function automatic logic window_hit();
        int klen;
        int plen;
        klen = int'(key_len);
        if (klen > MAX_KEY_BYTES_DEF) klen = MAX_KEY_BYTES_DEF;
        plen = klen + 4;
        if (win_fill < plen) return 1'b0;
        for (int k = 0; k < plen; k++) begin
            if (recent[plen - 1 - k] != pattern_char(k, klen)) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_result(input logic [7:0] b, input t_kind kind);
        if (burst_n < RES_PER_ITEM) begin
            burst[burst_n].value_byte = (kind == KIND_BYTE) ? b : 8'h00;
            burst[burst_n].kind       = kind;
            burst[burst_n].run_last   = 1'b0;
            burst_n++;
        end
    endtask

    task automatic clear_doc();
        doc_phase   = PH_SKIP;
        win_fill    = 0;
        skipped     = '0;
        prev_was_bs = 1'b0;
        esc_open    = 1'b0;
        for (int i = 0; i < WIN_DEPTH; i++) recent[i] = 8'h00;
    endtask

    // Search phase: shift the byte into the window and look for the pattern.
    task automatic shift_in(input logic [7:0] b);
        for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        if (win_fill < WIN_DEPTH) win_fill++;
        if (window_hit()) begin
            doc_phase   = PH_VALUE;
            prev_was_bs = 1'b0;
            esc_open    = 1'b0;
        end
    endtask

    // Value phase: unescape, and stop at a quote not preceded by a raw backslash.
    task automatic unescape(input logic [7:0] b);
        if (b == CH_QUOTE && !prev_was_bs) begin
            add_result(8'h00, KIND_DONE);
            doc_phase = PH_DONE;
            esc_open  = 1'b0;
        end else if (esc_open) begin
            esc_open = 1'b0;
            case (b)
                CH_N:      add_result(CH_LF, KIND_BYTE);
                CH_T:      add_result(CH_TAB, KIND_BYTE);
                CH_R:      add_result(CH_CR, KIND_BYTE);
                CH_QUOTE:  add_result(CH_QUOTE, KIND_BYTE);
                CH_BSLASH: add_result(CH_BSLASH, KIND_BYTE);
                default: begin
                    // An unknown escape keeps its backslash.
                    add_result(CH_BSLASH, KIND_BYTE);
                    add_result(b, KIND_BYTE);
                end
            endcase
        end else if (b == CH_BSLASH) begin
            esc_open = 1'b1;
        end else begin
            add_result(b, KIND_BYTE);
        end
        prev_was_bs = (b == CH_BSLASH);
    endtask

    // Works out the results of one accepted document byte and queues them.
    task automatic extract_step(input logic [7:0] b, input logic doc_end);
        burst_n = 0;
        case (doc_phase)
            PH_SKIP: begin
                if (skipped < skip_len) begin
                    skipped++;
                end else begin
                    doc_phase = PH_SEARCH;
                    shift_in(b);
                end
            end
            PH_SEARCH: shift_in(b);
            PH_VALUE:  unescape(b);
            default: ;
        endcase
        if (doc_end) begin
            if (doc_phase != PH_DONE) add_result(8'h00, KIND_FAIL);
            clear_doc();
        end
        for (int i = 0; i < burst_n; i++) begin
            if (i == burst_n - 1) burst[i].run_last = 1'b1;
            extracted_q.push_back(burst[i]);
        end
    endtask

    task automatic report_mismatch(input string why, input t_result want);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns: %s: expected byte %h kind %0d last %b, got byte %h kind %0d last %b",
                     $time, why, want.value_byte, want.kind, want.run_last,
                     m_tdata, m_tuser, m_tlast);
        end
    endtask

    // All sampling happens at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_lo       = '0;
            key_hi       = '0;
            key_len      = '0;
            skip_len     = '0;
            o_fail_count = 0;
            clear_doc();
            extracted_q.delete();
        end else begin
            // Result transaction: compare against the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (extracted_q.size() == 0) begin
                    report_mismatch("unexpected result", '0);
                end else begin
                    oldest = extracted_q.pop_front();
                    if (m_tdata !== oldest.value_byte || m_tuser !== oldest.kind ||
                        m_tlast !== oldest.run_last) begin
                        report_mismatch("result mismatch", oldest);
                    end
                end
            end

            // Register write, effective at once.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_LO:  key_lo   = i_cfg_data;
                    REG_KEY_HI:  key_hi   = i_cfg_data;
                    REG_KEY_LEN: key_len  = i_cfg_data[4:0];
                    REG_SKIP:    skip_len = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Document transaction.
            if (s_tvalid && s_tready) extract_step(s_tdata, s_tlast);
        end
        o_pending = extracted_q.size();
    end

endmodule

[sim/json_string_field_extract_top_tb.sv]
// Testbench top for the JSON string field extractor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module json_string_field_extract_top_tb
    import jsfe_pkg::*;
();

    typedef enum int {
        DOC_GOOD,
        DOC_CUT,
        DOC_NEAR,
        DOC_NOISE
    } t_doc_shape;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int          pending;
    int          fail_count;

    // Idling percentages of the current phase.
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    // Key as last written, for building documents that match it.
    logic [127:0] cur_key;
    logic [4:0]   cur_key_len;

    logic [7:0]  doc_q [$];
    int          bytes_sent;

    json_string_field_extract_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    json_string_field_extract_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // Sends one document byte as a single transaction; starts and ends at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    // Holds the sender back until every predicted result has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [63:0] len_w, input logic [63:0] skip_w);
        write_reg(REG_KEY_LO, lo);
        write_reg(REG_KEY_HI, hi);
        write_reg(REG_KEY_LEN, len_w);
        write_reg(REG_SKIP, skip_w);
        i_cfg_we    <= 1'b0;
        cur_key     = {hi, lo};
        cur_key_len = len_w[4:0];
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
            default: begin src_idle_pct = 20; sink_stall_pct = 20; end
        endcase
    endtask

    // A plain value character: anything but quote and backslash.
    function automatic logic [7:0] value_char();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == CH_QUOTE || v == CH_BSLASH);
        return v;
    endfunction

    // The byte after a backslash: a known escape or, now and then, an unknown one.
    function automatic logic [7:0] escape_char();
        logic [7:0] v;
        case ($urandom_range(5))
            0: v = CH_N;
            1: v = CH_T;
            2: v = CH_R;
            3: v = CH_QUOTE;
            4: v = CH_BSLASH;
            default: begin
                do v = 8'($urandom_range(255));
                while (v == CH_N || v == CH_T || v == CH_R || v == CH_QUOTE || v == CH_BSLASH);
            end
        endcase
        return v;
    endfunction

    // Builds a document around the current key: prefix, pattern, value, closing quote, tail; or a noise document.
    task automatic build_doc(input t_doc_shape shape);
        int klen;
        int pat_at;
        int pos;
        int n_val;
        doc_q.delete();
        if (shape == DOC_NOISE) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(3))
                    0: doc_q.push_back(CH_QUOTE);
                    1: doc_q.push_back(CH_COLON);
                    2: doc_q.push_back(CH_BSLASH);
                    default: doc_q.push_back(8'($urandom_range(255)));
                endcase
            end
            return;
        end
        klen = (cur_key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : int'(cur_key_len);
        repeat ($urandom_range(0, 4)) doc_q.push_back(8'($urandom_range(255)));
        pat_at = doc_q.size();
        doc_q.push_back(CH_QUOTE);
        for (int i = 0; i < klen; i++) doc_q.push_back(cur_key[8*i +: 8]);
        doc_q.push_back(CH_QUOTE);
        doc_q.push_back(CH_COLON);
        doc_q.push_back(CH_QUOTE);
        // A near miss flips one bit somewhere in the pattern.
        if (shape == DOC_NEAR) begin
            pos = $urandom_range(pat_at, doc_q.size() - 1);
            doc_q[pos] = doc_q[pos] ^ 8'(1 << $urandom_range(7));
        end
        n_val = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (n_val) begin
            if ($urandom_range(4) < 3) begin
                doc_q.push_back(value_char());
            end else begin
                doc_q.push_back(CH_BSLASH);
                doc_q.push_back(escape_char());
            end
        end
        // A cut document ends inside the value, sometimes on a lone backslash.
        if (shape == DOC_CUT) begin
            if ($urandom_range(3) == 0) doc_q.push_back(CH_BSLASH);
            return;
        end
        doc_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) doc_q.push_back(8'($urandom_range(255)));
    endtask

    initial begin
        int          grp;
        int          first_item;
        int          pick;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_w;
        logic [63:0] skip_w;
        t_doc_shape  shape;

        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_KEY_LO;
        i_cfg_data  = '0;
        cur_key     = '0;
        cur_key_len = '0;
        bytes_sent  = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset key is empty: every escape, an unknown escape, a zero byte, bytes after completion.
        doc_q = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE,
                  CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_R,
                  CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h71,
                  8'h00, CH_QUOTE, 8'h78, 8'hFF};
        send_doc();
        wait_idle();

        // All ones everywhere: oversized key length and a skip longer than the document.
        apply_settings('1, '1, '1, '1);
        doc_q = '{CH_QUOTE, 8'hFF};
        send_doc();
        wait_idle();

        // A zero key byte after two skipped bytes, with the match on the final byte.
        apply_settings('0, '0, 64'd1, 64'd2);
        doc_q = '{8'h61, 8'h62, CH_QUOTE, 8'h00, CH_QUOTE, CH_COLON, CH_QUOTE};
        send_doc();
        wait_idle();

        // Random part: a new setting and idling phase every three documents.
        grp        = 0;
        first_item = bytes_sent;
        while (bytes_sent - first_item < 250 || grp < 4) begin
            case ($urandom_range(4))
                0: lo = '0;
                1: lo = '1;
                default: lo = {$urandom, $urandom};
            endcase
            case ($urandom_range(4))
                0: hi = '0;
                1: hi = '1;
                default: hi = {$urandom, $urandom};
            endcase
            case ($urandom_range(9))
                0: len_w = 64'd0;
                1: len_w = 64'd16;
                2: len_w = 64'($urandom_range(17, 31));
                default: len_w = 64'($urandom_range(1, 4));
            endcase
            skip_w = ($urandom_range(3) == 0) ? 64'($urandom_range(1, 3)) : 64'd0;
            // Unused upper data bits must be ignored.
            if ($urandom_range(1) == 1) len_w = ({$urandom, $urandom} & ~64'h1F) | len_w;
            if ($urandom_range(1) == 1) skip_w = ({$urandom, $urandom} & ~64'hFFFF) | skip_w;
            apply_settings(lo, hi, len_w, skip_w);
            set_idling(grp % 4);

            repeat (3) begin
                pick = $urandom_range(19);
                if (pick < 13)      shape = DOC_GOOD;
                else if (pick < 16) shape = DOC_CUT;
                else if (pick < 18) shape = DOC_NEAR;
                else                shape = DOC_NOISE;
                build_doc(shape);
                send_doc();
            end
            wait_idle();
            grp++;
        end

        wait_idle();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/jsfe_pkg.sv
hw/rtl/json_string_field_extract_top.sv
sim/json_string_field_extract_checker.sv
sim/json_string_field_extract_top_tb.sv
